>>> rtl/tdts_pkg.sv
// Shared codes and field widths for the tick-driven tone sequencer.
package tdts_pkg;

    localparam int unsigned NOTE_DEPTH_DEF = 1024;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned FREQ_W  = 16;
    localparam int unsigned DUR_W   = 16;
    localparam int unsigned TONE_W  = 15;
    localparam int unsigned POS_W   = 11;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PLAY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GOTO  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd4;

    // Articulation modes.
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_LEGATO   = 2'd0;
    localparam mode_t MODE_NORMAL   = 2'd1;
    localparam mode_t MODE_STACCATO = 2'd2;

    // Command codes held in the tone field of a zero-duration entry.
    localparam logic [FREQ_W-1:0] CMD_END      = 16'h0000;
    localparam logic [FREQ_W-1:0] CMD_STOP     = 16'hFFFF;
    localparam logic [FREQ_W-1:0] CMD_NORMAL   = 16'hFFFE;
    localparam logic [FREQ_W-1:0] CMD_LEGATO   = 16'hFFFD;
    localparam logic [FREQ_W-1:0] CMD_STACCATO = 16'hFFFC;

    // Width of the offset operand of the modulo-depth reducer.
    localparam int unsigned RED_W = 17;

endpackage

>>> rtl/tick_driven_tone_sequencer.sv
// Tick-driven tone sequencer: note store, playback state and handshakes.
//
//  Channel | Ports                                           | Direction
//  --------+-------------------------------------------------+----------
//  input   | s_valid s_ready s_kind s_note_index             | in
//          | s_note_freq s_note_duration                     |
//  result  | m_valid m_ready m_tone_on m_tone_freq           | out
//          | m_playing m_position                            |
//
// Every input transaction runs in two phases: the first reads the note store at the entry
// after the pointer and forms the reducer's quotient estimate, the second applies the item
// and loads the output register. The registered read data of the store makes this split.
// A new transaction is taken in the cycle the previous one finishes, so items never overlap.
// The synchronous reset clears all control state; the note store needs no clearing pass.
// A stalled result channel holds the finishing item in the input register until it frees.
module tick_driven_tone_sequencer
    import tdts_pkg::*;
#(
    parameter int unsigned NOTE_DEPTH = NOTE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [KIND_W-1:0]        s_kind,
    input  logic [INDEX_W-1:0]       s_note_index,
    input  logic signed [FREQ_W-1:0] s_note_freq,
    input  logic [DUR_W-1:0]         s_note_duration,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_tone_on,
    output logic [TONE_W-1:0]        m_tone_freq,
    output logic                     m_playing,
    output logic signed [POS_W-1:0]  m_position
);

    localparam int unsigned AW = $clog2(NOTE_DEPTH);

    // Reducer constants. RED_OFS is a multiple of the depth that lifts any
    // signed 16-bit value to a nonnegative one; RED_RCP approximates the
    // reciprocal of the depth so the quotient estimate is low by at most one.
    localparam int unsigned RED_OFS = NOTE_DEPTH * ((32768 + NOTE_DEPTH - 1) / NOTE_DEPTH);
    localparam int unsigned RED_RCP = (1 << RED_W) / NOTE_DEPTH;
    localparam logic [RED_W:0]   DEPTH_X = (RED_W + 1)'(NOTE_DEPTH);
    localparam logic [RED_W-1:0] DEPTH_R = RED_W'(NOTE_DEPTH);
    localparam logic [AW:0]      DEPTH_P = (AW + 1)'(NOTE_DEPTH);

    // A stored entry keeps the jump target already reduced to a pointer value,
    // so that the playback step needs no division.
    typedef struct packed {
        logic [DUR_W-1:0]  dur;
        logic [FREQ_W-1:0] freq;
        logic [AW-1:0]     jmp;
    } entry_t;

    entry_t note_mem [NOTE_DEPTH];

    // Input register and phase.
    logic                  in_vld_reg;
    logic                  phase_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [DUR_W-1:0]      dur_reg;

    // Playback state.
    logic [AW-1:0]         ptr_reg,    ptr_next;
    logic [DUR_W-1:0]      cnt_reg,    cnt_next;
    logic                  gap_reg,    gap_next;
    mode_t                 mode_reg,   mode_next;
    logic                  loaded_reg, loaded_next;
    logic                  active_reg, active_next;
    logic                  run_reg,    run_next;
    logic                  tone_on_reg, tone_on_next;
    logic [TONE_W-1:0]     tone_freq_reg, tone_freq_next;

    // Memory read data and reducer pipeline.
    entry_t                rd_reg;
    logic [RED_W-1:0]      red_n_reg;
    logic [RED_W-1:0]      red_q_reg;

    // Output register.
    logic                  m_valid_reg;
    logic                  m_tone_on_reg;
    logic [TONE_W-1:0]     m_tone_freq_reg;
    logic                  m_playing_reg;
    logic [POS_W-1:0]      m_position_reg;
    logic [POS_W-1:0]      position_next;

    logic                  in_fire;
    logic                  exec_fire;
    logic                  out_free;
    logic                  rd_en;
    logic                  wr_en;
    logic [AW:0]           ptr_inc;
    logic [AW-1:0]         ptr_adv;
    logic [31:0]           index_w;
    logic [AW-1:0]         wr_addr;

    logic [RED_W-1:0]      red_src;
    logic [RED_W:0]        red_sum;
    logic [2*RED_W-1:0]    red_prod;
    logic [2*RED_W-1:0]    red_qd;
    logic [RED_W:0]        red_rem;
    logic [RED_W:0]        red_mod;
    logic [AW-1:0]         red_ptr;
    logic [31:0]           pos_abs;
    logic [POS_W-1:0]      pos_low;

    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = in_vld_reg && phase_reg && out_free;
    assign s_ready   = !in_vld_reg || exec_fire;
    assign in_fire   = s_valid && s_ready;
    assign rd_en     = in_vld_reg && !phase_reg;

    // Next entry after the pointer: wraps at the depth and skips the header.
    assign ptr_inc = {1'b0, ptr_reg} + (AW + 1)'(1);
    assign ptr_adv = (ptr_inc == DEPTH_P) ? AW'(1) : ptr_inc[AW-1:0];

    assign index_w = 32'(index_reg);
    assign wr_addr = index_w[AW-1:0];
    assign wr_en   = exec_fire && (kind_reg == KIND_WRITE) && (index_w < 32'(NOTE_DEPTH));

    // Reducer, first half: offset to a nonnegative value and estimate the
    // quotient. A write reduces its tone field, a go-to its note index.
    always_comb begin
        if (kind_reg == KIND_WRITE) begin
            red_src = {freq_reg[FREQ_W-1], freq_reg};
        end else begin
            red_src = RED_W'(index_reg);
        end
        red_sum  = {red_src[RED_W-1], red_src} + (RED_W + 1)'(RED_OFS);
        red_prod = red_sum[RED_W-1:0] * RED_W'(RED_RCP);
    end

    // Reducer, second half: remainder with one correction, then the note
    // number minus one, with a result of zero standing for note one.
    always_comb begin
        red_qd  = red_q_reg * DEPTH_R;
        red_rem = {1'b0, red_n_reg} - red_qd[RED_W:0];
        if (red_rem >= DEPTH_X) begin
            red_mod = red_rem - DEPTH_X;
        end else begin
            red_mod = red_rem;
        end
        if (red_mod == '0) begin
            red_ptr = '0;
        end else begin
            red_ptr = red_mod[AW-1:0] - AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            note_mem[wr_addr] <= '{dur: dur_reg, freq: freq_reg, jmp: red_ptr};
        end
        if (rd_en) begin
            rd_reg <= note_mem[ptr_adv];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            red_n_reg <= red_sum[RED_W-1:0];
            red_q_reg <= red_prod[2*RED_W-1:RED_W];
        end
        if (in_fire) begin
            kind_reg  <= s_kind;
            index_reg <= s_note_index;
            freq_reg  <= s_note_freq;
            dur_reg   <= s_note_duration;
        end
    end

    // Playback step: applies the item in the input register.
    always_comb begin
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        gap_next       = gap_reg;
        mode_next      = mode_reg;
        loaded_next    = loaded_reg;
        active_next    = active_reg;
        run_next       = run_reg;
        tone_on_next   = tone_on_reg;
        tone_freq_next = tone_freq_reg;

        unique case (kind_reg)
            KIND_TICK: begin
                if (run_reg && active_reg) begin
                    if (cnt_reg != '0) begin
                        cnt_next = cnt_reg - DUR_W'(1);
                    end else begin
                        if (mode_reg != MODE_LEGATO) begin
                            tone_on_next   = 1'b0;
                            tone_freq_next = '0;
                        end
                        if (!gap_reg) begin
                            // Staccato rest tick after a note.
                            gap_next = 1'b1;
                        end else begin
                            ptr_next = ptr_adv;
                            cnt_next = rd_reg.dur;
                            if (rd_reg.dur == '0) begin
                                unique case (rd_reg.freq)
                                    CMD_END: begin
                                        tone_on_next   = 1'b0;
                                        tone_freq_next = '0;
                                        loaded_next    = 1'b0;
                                        active_next    = 1'b0;
                                    end
                                    CMD_STOP:     active_next = 1'b0;
                                    CMD_LEGATO:   mode_next   = MODE_LEGATO;
                                    CMD_NORMAL:   mode_next   = MODE_NORMAL;
                                    CMD_STACCATO: mode_next   = MODE_STACCATO;
                                    default:      ptr_next    = rd_reg.jmp;
                                endcase
                            end else begin
                                if (mode_reg == MODE_STACCATO) begin
                                    gap_next = 1'b0;
                                end
                                if (rd_reg.freq[FREQ_W-1] || rd_reg.freq == '0) begin
                                    tone_on_next   = 1'b0;
                                    tone_freq_next = '0;
                                end else begin
                                    tone_on_next   = 1'b1;
                                    tone_freq_next = rd_reg.freq[TONE_W-1:0];
                                end
                            end
                        end
                    end
                end
            end
            KIND_PLAY: begin
                tone_on_next   = 1'b0;
                tone_freq_next = '0;
                loaded_next    = 1'b1;
                active_next    = 1'b1;
                ptr_next       = '0;
                cnt_next       = '0;
                run_next       = 1'b1;
            end
            KIND_GOTO: begin
                if (loaded_reg) begin
                    tone_on_next   = 1'b0;
                    tone_freq_next = '0;
                    ptr_next       = red_ptr;
                    active_next    = 1'b1;
                    cnt_next       = '0;
                    run_next       = 1'b1;
                end
            end
            KIND_STOP: begin
                run_next       = 1'b0;
                tone_on_next   = 1'b0;
                tone_freq_next = '0;
            end
            default: begin
                // Writes touch only the note store; unused kinds do nothing.
            end
        endcase

        // The header entry reports as note one; a stopped program reports
        // its note number negated.
        pos_abs = 32'(ptr_next) + ((ptr_next == '0) ? 32'd1 : 32'd0);
        pos_low = pos_abs[POS_W-1:0];
        if (loaded_next && active_next) begin
            position_next = run_next ? pos_low : (POS_W'(0) - pos_low);
        end else begin
            position_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg    <= 1'b0;
            phase_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            gap_reg       <= 1'b1;
            mode_reg      <= MODE_NORMAL;
            loaded_reg    <= 1'b0;
            active_reg    <= 1'b0;
            run_reg       <= 1'b0;
            tone_on_reg   <= 1'b0;
            tone_freq_reg <= '0;
        end else begin
            if (in_fire) begin
                in_vld_reg <= 1'b1;
                phase_reg  <= 1'b0;
            end else if (exec_fire) begin
                in_vld_reg <= 1'b0;
                phase_reg  <= 1'b0;
            end else if (rd_en) begin
                phase_reg  <= 1'b1;
            end

            if (exec_fire) begin
                m_valid_reg   <= 1'b1;
                ptr_reg       <= ptr_next;
                cnt_reg       <= cnt_next;
                gap_reg       <= gap_next;
                mode_reg      <= mode_next;
                loaded_reg    <= loaded_next;
                active_reg    <= active_next;
                run_reg       <= run_next;
                tone_on_reg   <= tone_on_next;
                tone_freq_reg <= tone_freq_next;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_tone_on_reg   <= tone_on_next;
            m_tone_freq_reg <= tone_freq_next;
            m_playing_reg   <= active_next && run_next;
            m_position_reg  <= position_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tone_on   = m_tone_on_reg;
    assign m_tone_freq = m_tone_freq_reg;
    assign m_playing   = m_playing_reg;
    assign m_position  = $signed(m_position_reg);

endmodule

>>> tb/sv/tick_driven_tone_sequencer_tb.sv
// Self-checking testbench for the tick-driven tone sequencer with a built-in playback predictor.
module tick_driven_tone_sequencer_tb;
    import tdts_pkg::*;

    localparam int DEPTH = NOTE_DEPTH_DEF;

    // Kinds 5 to 7 have no meaning and must leave the block untouched.
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

    // One result transaction, laid out field by field as the result channel carries it.
    typedef struct packed {
        logic                    tone_on;
        logic [TONE_W-1:0]       tone_freq;
        logic                    playing;
        logic signed [POS_W-1:0] position;
    } tone_result_t;

    // Every input has a known value from time zero on.
    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [KIND_W-1:0]        s_kind = KIND_TICK;
    logic [INDEX_W-1:0]       s_note_index = '0;
    logic signed [FREQ_W-1:0] s_note_freq = '0;
    logic [DUR_W-1:0]         s_note_duration = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_tone_on;
    logic [TONE_W-1:0]        m_tone_freq;
    logic                     m_playing;
    logic signed [POS_W-1:0]  m_position;

    tick_driven_tone_sequencer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_note_index    (s_note_index),
        .s_note_freq     (s_note_freq),
        .s_note_duration (s_note_duration),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tone_on       (m_tone_on),
        .m_tone_freq     (m_tone_freq),
        .m_playing       (m_playing),
        .m_position      (m_position)
    );

    // Shadow copy of the playback state. It is advanced once per accepted input
    // transaction, in the order the block accepts them.
    logic [31:0]        song_mem [DEPTH];
    bit                 song_written [DEPTH];
    logic [INDEX_W-1:0] play_ptr;
    logic [DUR_W-1:0]   ticks_left;
    bit                 rest_taken;
    mode_t              mode_q;
    bit                 song_loaded;
    bit                 song_live;
    bit                 is_running;
    bit                 tone_en;
    logic [TONE_W-1:0]  tone_hz;

    // Results still owed by the block, oldest first.
    tone_result_t tone_due[$];
    tone_result_t due;

    int fail_count = 0;
    int items_done = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Playback predictor
    // ------------------------------------------------------------------

    function automatic void clear_song_state();
        song_written = '{default: 1'b0};
        play_ptr     = '0;
        ticks_left   = '0;
        rest_taken   = 1'b1;
        mode_q       = MODE_NORMAL;
        song_loaded  = 1'b0;
        song_live    = 1'b0;
        is_running   = 1'b0;
        tone_en      = 1'b0;
        tone_hz      = '0;
    endfunction

    function automatic void mute_tone();
        tone_en = 1'b0;
        tone_hz = '0;
    endfunction

    // A signed note number reduced modulo the store depth. Entry 0 holds the
    // header, so a result of 0 is turned into 1.
    function automatic int wrap_target(input int v);
        int r;
        r = ((v % DEPTH) + DEPTH) % DEPTH;
        return (r == 0) ? 1 : r;
    endfunction

    // Entry that follows p during normal advance; wraps past the end and skips the header.
    function automatic logic [INDEX_W-1:0] next_slot(input logic [INDEX_W-1:0] p);
        int n;
        n = (int'(p) + 1) % DEPTH;
        return INDEX_W'((n == 0) ? 1 : n);
    endfunction

    // Entry that the next tick would fetch, or -1 if that tick fetches nothing.
    function automatic int fetch_on_next_tick();
        if (!is_running || !song_live || ticks_left != 0 || !rest_taken)
            return -1;
        return int'(next_slot(play_ptr));
    endfunction

    function automatic void tick_song();
        logic [31:0]       entry;
        logic [FREQ_W-1:0] fr;
        if (!is_running || !song_live)
            return;
        if (ticks_left != 0) begin
            ticks_left = ticks_left - 1'b1;
            return;
        end
        // The running note ends here. Legato lets it ring into the next one.
        if (mode_q != MODE_LEGATO)
            mute_tone();
        // Staccato owes one silent tick before the advance.
        if (!rest_taken) begin
            rest_taken = 1'b1;
            return;
        end
        play_ptr   = next_slot(play_ptr);
        entry      = song_mem[play_ptr];
        fr         = entry[15:0];
        ticks_left = entry[31:16];
        if (ticks_left == 0) begin
            case (fr)
                CMD_END: begin
                    mute_tone();
                    song_loaded = 1'b0;
                    song_live   = 1'b0;
                end
                CMD_STOP:     song_live = 1'b0;
                CMD_NORMAL:   mode_q = MODE_NORMAL;
                CMD_LEGATO:   mode_q = MODE_LEGATO;
                CMD_STACCATO: mode_q = MODE_STACCATO;
                // Any other code jumps; the pointer lands one short so that
                // the next advance fetches the target itself.
                default:      play_ptr = INDEX_W'(wrap_target($signed(fr)) - 1);
            endcase
        end else begin
            if (mode_q == MODE_STACCATO)
                rest_taken = 1'b0;
            if ($signed(fr) <= 0) begin
                mute_tone();
            end else begin
                tone_en = 1'b1;
                tone_hz = fr[TONE_W-1:0];
            end
        end
    endfunction

    // Applies one accepted item to the shadow state and returns the result
    // the block has to produce for it.
    function automatic tone_result_t next_tone_result(input logic [KIND_W-1:0] kind,
                                                      input logic [INDEX_W-1:0] idx,
                                                      input logic [FREQ_W-1:0] freq,
                                                      input logic [DUR_W-1:0] dur);
        tone_result_t r;
        int           spot;
        case (kind)
            KIND_TICK: tick_song();
            KIND_WRITE: begin
                song_mem[idx]     = {dur, freq};
                song_written[idx] = 1'b1;
            end
            KIND_PLAY: begin
                mute_tone();
                song_loaded = 1'b1;
                song_live   = 1'b1;
                play_ptr    = '0;
                ticks_left  = '0;
                is_running  = 1'b1;
            end
            KIND_GOTO: begin
                if (song_loaded) begin
                    mute_tone();
                    play_ptr   = INDEX_W'(wrap_target(int'(idx)) - 1);
                    song_live  = 1'b1;
                    ticks_left = '0;
                    is_running = 1'b1;
                end
            end
            KIND_STOP: begin
                is_running = 1'b0;
                mute_tone();
            end
            default: ;
        endcase
        r.tone_on   = tone_en;
        r.tone_freq = tone_hz;
        r.playing   = song_live && is_running;
        r.position  = '0;
        // Pointer 0 (before the first fetch) reports as note 1.
        if (song_loaded && song_live) begin
            spot = int'(play_ptr) + ((play_ptr == 0) ? 1 : 0);
            r.position = is_running ? POS_W'(spot) : POS_W'(-spot);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result channel: random stalls, long hold-offs and checking
    // ------------------------------------------------------------------

    // The receiver either holds off for a counted stretch or stalls at random.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string fld,
                                        input logic signed [15:0] want,
                                        input logic signed [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fld, want, got);
            fail_count++;
        end
    endfunction

    // Every accepted result transaction is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (tone_due.size() == 0) begin
                $error("result transaction arrived with no expected result pending");
                fail_count++;
            end else begin
                due = tone_due.pop_front();
                check_field("tone_on", due.tone_on, m_tone_on);
                check_field("tone_freq", due.tone_freq, m_tone_freq);
                check_field("playing", due.playing, m_playing);
                check_field("position", due.position, m_position);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------

    // Offers one item, holding valid and payload steady until the transaction
    // completes, then records the predicted result. The random idle gap comes
    // first; with no gap, valid simply stays high into the next transaction.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [INDEX_W-1:0] idx,
                             input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_note_index    <= idx;
        s_note_freq     <= freq;
        s_note_duration <= dur;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tone_due.push_back(next_tone_result(kind, idx, freq, dur));
        if (kind <= KIND_STOP)
            items_done++;
    endtask

    // A tick must never make the block fetch an entry that was never written.
    // When it would, that entry is filled first with either an end-of-program
    // command or a short note. The tick's unused fields carry random bits.
    task automatic send_tick();
        int nxt;
        nxt = fetch_on_next_tick();
        if (nxt >= 0 && !song_written[nxt]) begin
            if ($urandom_range(2) == 0)
                send_item(KIND_WRITE, INDEX_W'(nxt), CMD_END, '0);
            else
                send_item(KIND_WRITE, INDEX_W'(nxt), FREQ_W'($urandom_range(1, 3000)),
                          DUR_W'($urandom_range(1, 3)));
        end
        send_item(KIND_TICK, INDEX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom));
    endtask

    // Writes one program entry. The last entry usually terminates the program:
    // end, stop, or a jump back to the start whose target is given with a
    // random multiple of the depth added, so that the reduction is exercised.
    // Sometimes the last entry is a plain note and play runs on past it.
    task automatic write_score_entry(input int idx, input bit is_last, input int start);
        logic [FREQ_W-1:0] fr;
        logic [DUR_W-1:0]  du;
        int                pick;
        int                jv;
        pick = $urandom_range(99);
        du   = '0;
        if (is_last && pick < 90) begin
            case (pick % 3)
                0:       fr = CMD_END;
                1:       fr = CMD_STOP;
                default: begin
                    jv = start + DEPTH * (int'($urandom_range(63)) - 32);
                    fr = FREQ_W'(jv);
                end
            endcase
        end else if (pick < 30) begin
            case (pick % 3)
                0:       fr = CMD_NORMAL;
                1:       fr = CMD_LEGATO;
                default: fr = CMD_STACCATO;
            endcase
        end else begin
            // Mostly audible tones; now and then any 16-bit value, zero and
            // negative tones among them, which play as silence.
            fr = (pick < 85) ? FREQ_W'($urandom_range(1, 4000)) : FREQ_W'($urandom);
            du = (pick % 10 == 0) ? DUR_W'($urandom_range(4, 20)) : DUR_W'($urandom_range(1, 3));
        end
        send_item(KIND_WRITE, INDEX_W'(idx), fr, du);
    endtask

    // A well-formed sequence: load a short program, start it with play or
    // goto, then mostly ticks with an occasional stop, goto or restart.
    task automatic play_random_program();
        int start;
        int len;
        int n_ticks;
        start = ($urandom_range(9) < 6) ? 1 : $urandom_range(1, DEPTH - 9);
        len   = $urandom_range(2, 8);
        for (int i = 0; i < len; i++)
            write_score_entry(start + i, i == len - 1, start);
        if (start == 1 && $urandom_range(1) == 1)
            send_item(KIND_PLAY, INDEX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom));
        else
            send_item(KIND_GOTO, (start == 1 && $urandom_range(1) == 1) ? '0 : INDEX_W'(start),
                      FREQ_W'($urandom), DUR_W'($urandom));
        n_ticks = $urandom_range(2 * len, 8 * len);
        repeat (n_ticks) begin
            case ($urandom_range(19))
                0: send_item(KIND_STOP, INDEX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom));
                1: send_item(KIND_GOTO, INDEX_W'(start + $urandom_range(len - 1)),
                             FREQ_W'($urandom), DUR_W'($urandom));
                2: send_item(KIND_PLAY, INDEX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom));
                default: send_tick();
            endcase
        end
    endtask

    // Noise: any kind, spare kinds included, with every field fully random.
    task automatic send_noise_item();
        logic [KIND_W-1:0] kind;
        kind = KIND_W'($urandom);
        if (kind == KIND_TICK)
            send_tick();
        else
            send_item(kind, INDEX_W'($urandom), FREQ_W'($urandom), DUR_W'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh from reset nothing is loaded: a tick does nothing, go to note is
    // ignored, and a spare kind with all fields at their maximum changes nothing.
    task automatic test_idle_block();
        send_tick();
        send_item(KIND_GOTO, 10'd5, '0, '0);
        send_item(KIND_SPARE, '1, '1, '1);
    endtask

    // A hand-built program walking through the corner cases: extreme tones and
    // durations, a silent negative tone, the staccato gap, a jump given as a
    // large negative value, the stop command, go to note 0, and the advance
    // that wraps from the last entry back to entry 1.
    task automatic test_directed_program();
        send_item(KIND_WRITE, 10'd0, '1, '1);             // header, never played
        send_item(KIND_WRITE, 10'd1, 16'h7FFF, 16'd1);    // loudest tone
        send_item(KIND_WRITE, 10'd2, CMD_STACCATO, '0);
        send_item(KIND_WRITE, 10'd3, 16'h8000, 16'd1);    // most negative tone, silent
        send_item(KIND_WRITE, 10'd4, 16'h83FF, '0);       // jump, reduces to entry 1023
        send_item(KIND_WRITE, 10'd1023, 16'h0001, '1);    // lowest tone, longest duration
        send_item(KIND_PLAY, '0, '0, '0);
        repeat (8) send_tick();
        send_item(KIND_STOP, '0, '0, '0);                 // position turns negative
        send_item(KIND_GOTO, 10'd0, '0, '0);              // note 0 is taken as note 1
        send_item(KIND_WRITE, 10'd1, CMD_STOP, '0);
        repeat (2) send_tick();                           // staccato gap, then the stop command
        send_item(KIND_WRITE, 10'd1023, 16'd500, 16'd1);
        send_item(KIND_GOTO, 10'd1023, '0, '0);
        repeat (4) send_tick();                           // last entry, gap, wrap to entry 1
    endtask

    // The receiver holds off for a long counted stretch while the sender keeps
    // offering items, so the block fills up and must stall its input.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 60;
        repeat (3) play_random_program();
    endtask

    // Mostly well-formed programs with random content, the rest noise.
    task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                       input int budget);
        int stop_at;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        stop_at        = items_done + budget;
        while (items_done < stop_at) begin
            if ($urandom_range(9) < 8)
                play_random_program();
            else
                send_noise_item();
        end
    endtask

    // Waits until every expected result has arrived, lets the pipeline settle
    // and reports.
    task automatic finish_run();
        s_valid <= 1'b0;
        while (tone_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    endtask

    initial begin
        clear_song_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_block();
        test_directed_program();
        test_output_backpressure();
        test_random_traffic(0, 0, 300);
        test_random_traffic(84, 0, 300);
        test_random_traffic(0, 84, 300);
        test_random_traffic(38, 38, 300);
        finish_run();
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
